// ===== rtl/core/trm_pkg.sv =====
// ----------------------------------------------------------------------------
// trm_pkg
// Shared codes, defaults and the controller state type of the trie route
// match engine.
// ----------------------------------------------------------------------------
package trm_pkg;

  localparam int NODES_DEF    = 1024;
  localparam int ROUTES_DEF   = 256;
  localparam int MAX_PATH_DEF = 256;

  // Operation codes of an input item.
  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_INS_CHR = 3'd1;
  localparam logic [2:0] OP_INS_END = 3'd2;
  localparam logic [2:0] OP_LKP_CHR = 3'd3;
  localparam logic [2:0] OP_LKP_END = 3'd4;

  // Status codes of a result item.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;

  // Route modes of an end insert.
  localparam logic [1:0] MODE_EXACT  = 2'd0;
  localparam logic [1:0] MODE_PREFIX = 2'd1;
  localparam logic [1:0] MODE_BOTH   = 2'd2;

  localparam logic KIND_EXACT  = 1'b0;
  localparam logic KIND_PREFIX = 1'b1;

  // Whitespace bytes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VTAB  = 8'h0b;
  localparam logic [7:0] CH_FEED  = 8'h0c;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_WRD,
    S_PAR,
    S_SIB,
    S_ALLOC,
    S_LINK,
    S_EI_CHK,
    S_EL_CHK,
    S_RESP
  } trm_state_t;

endpackage

// ===== rtl/core/trm_in_if.sv =====
// ----------------------------------------------------------------------------
// trm_in_if
// Input channel of the trie route match engine: valid, ready and one item.
// ----------------------------------------------------------------------------
interface trm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] symbol;
  logic [1:0] route_mode;
  logic [7:0] route_number;

  modport source (output valid, operation, symbol, route_mode, route_number, input ready);
  modport sink   (input valid, operation, symbol, route_mode, route_number, output ready);
endinterface

// ===== rtl/core/trm_out_if.sv =====
// ----------------------------------------------------------------------------
// trm_out_if
// Result channel of the trie route match engine: valid, ready and one item.
// ----------------------------------------------------------------------------
interface trm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       is_lookup;
  logic [7:0] matched_route;
  logic       match_kind;
  logic [7:0] remainder_offset;

  modport source (output valid, status, is_lookup, matched_route, match_kind,
                  remainder_offset, input ready);
  modport sink   (input valid, status, is_lookup, matched_route, match_kind,
                  remainder_offset, output ready);
endinterface

// ===== rtl/core/trm_ram.sv =====
// ----------------------------------------------------------------------------
// trm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module trm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/trie_route_match_engine.sv =====
// ----------------------------------------------------------------------------
// trie_route_match_engine
// Longest-prefix route matcher over a character trie kept in one node RAM.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  in_chan   in   valid / ready     operation, symbol, route_mode, route_number
//  out_chan  out  valid / ready     status, is_lookup, matched_route, match_kind,
//                                   remainder_offset
//  cfg       in   cfg_we            cfg_wdata (tokenize_insert)
//
// One item at a time. A character walks the sibling list of the current node
// through the RAM read port: S_WRD and S_PAR read the node, S_SIB each sibling
// in turn, S_ALLOC and S_LINK add a node on a miss, all twice when a pending
// space is inserted first. End items wait in S_RESP for the result register.
// After reset and after a clear, S_INIT writes the root node.
// A result waiting on out_chan does not block items that produce none.
// ----------------------------------------------------------------------------
module trie_route_match_engine
  import trm_pkg::*;
#(
  parameter int NODES    = NODES_DEF,
  parameter int ROUTES   = ROUTES_DEF,
  parameter int MAX_PATH = MAX_PATH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  trm_in_if.sink    in_chan,
  trm_out_if.source out_chan,
  input  logic   cfg_we,
  input  logic   cfg_wdata
);

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);
  localparam int LW = $clog2(MAX_PATH);

  typedef struct packed {
    logic [7:0]    ch;
    logic          child_v;
    logic [NW-1:0] child;
    logic          sib_v;
    logic [NW-1:0] sib;
    logic          ex_v;
    logic [7:0]    ex;
    logic          pf_v;
    logic [7:0]    pf;
  } node_t;

  localparam int EW = $bits(node_t);

  trm_state_t    state_r, state_nxt;
  logic          tok_r;
  logic [CW-1:0] used_r, used_nxt;
  logic          failed_r, failed_nxt;
  logic [NW-1:0] ins_cur_r, ins_cur_nxt;
  logic          pend_r, pend_nxt, has_r, has_nxt, err_r, err_nxt;
  logic [2:0]    err_code_r, err_code_nxt;
  logic [NW-1:0] lk_cur_r, lk_cur_nxt;
  logic          broken_r, broken_nxt, ovf_r, ovf_nxt;
  logic [LW-1:0] len_r, len_nxt, best_off_r, best_off_nxt;
  logic          best_v_r, best_v_nxt;
  logic [7:0]    best_r, best_nxt;
  logic [7:0]    sym_r, sym_nxt, route_r, route_nxt, app_ch_r, app_ch_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic          again_r, again_nxt, walk_lk_r, walk_lk_nxt;
  logic [NW-1:0] idx_r, idx_nxt;
  node_t         par_r, par_nxt;
  logic [2:0]    res_st_r, res_st_nxt;
  logic          res_lk_r, res_lk_nxt, res_kind_r, res_kind_nxt;
  logic [7:0]    res_rt_r, res_rt_nxt, res_off_r, res_off_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_st_r;
  logic          out_lk_r, out_kind_r;
  logic [7:0]    out_rt_r, out_off_r;
  logic          load_out;

  logic          ram_we;
  logic [NW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  node_t         rnode, wnode;

  logic found_c, miss_c, done_app_c, accept, space_c;

  trm_ram #(.WIDTH(EW), .DEPTH(NODES)) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rnode     = node_t'(ram_rdata);
  assign ram_wdata = EW'(wnode);

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && (state_r == S_IDLE);
  assign space_c = (in_chan.symbol == CH_SPACE) || (in_chan.symbol == CH_TAB) ||
                   (in_chan.symbol == CH_VTAB) || (in_chan.symbol == CH_FEED);

  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = out_st_r;
  assign out_chan.is_lookup        = out_lk_r;
  assign out_chan.matched_route    = out_rt_r;
  assign out_chan.match_kind       = out_kind_r;
  assign out_chan.remainder_offset = out_off_r;

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    failed_nxt   = failed_r;
    ins_cur_nxt  = ins_cur_r;
    pend_nxt     = pend_r;
    has_nxt      = has_r;
    err_nxt      = err_r;
    err_code_nxt = err_code_r;
    lk_cur_nxt   = lk_cur_r;
    broken_nxt   = broken_r;
    ovf_nxt      = ovf_r;
    len_nxt      = len_r;
    best_off_nxt = best_off_r;
    best_v_nxt   = best_v_r;
    best_nxt     = best_r;
    sym_nxt      = sym_r;
    route_nxt    = route_r;
    mode_nxt     = mode_r;
    app_ch_nxt   = app_ch_r;
    again_nxt    = again_r;
    walk_lk_nxt  = walk_lk_r;
    idx_nxt      = idx_r;
    par_nxt      = par_r;
    res_st_nxt   = res_st_r;
    res_lk_nxt   = res_lk_r;
    res_kind_nxt = res_kind_r;
    res_rt_nxt   = res_rt_r;
    res_off_nxt  = res_off_r;
    load_out     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_raddr    = '0;
    wnode        = '0;
    found_c      = 1'b0;
    miss_c       = 1'b0;
    done_app_c   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sym_nxt      = in_chan.symbol;
          route_nxt    = in_chan.route_number;
          mode_nxt     = in_chan.route_mode;
          res_kind_nxt = KIND_EXACT;
          res_rt_nxt   = '0;
          res_off_nxt  = '0;
          case (in_chan.operation)
            OP_CLEAR: begin
              used_nxt     = CW'(1);
              failed_nxt   = 1'b0;
              ins_cur_nxt  = '0;
              pend_nxt     = 1'b0;
              has_nxt      = 1'b0;
              err_nxt      = 1'b0;
              err_code_nxt = ST_OK;
              lk_cur_nxt   = '0;
              broken_nxt   = 1'b0;
              ovf_nxt      = 1'b0;
              len_nxt      = '0;
              best_v_nxt   = 1'b0;
              best_off_nxt = '0;
              state_nxt    = S_INIT;
            end
            OP_INS_CHR: begin
              walk_lk_nxt = 1'b0;
              if (failed_r || err_r) begin
                state_nxt = S_IDLE;
              end else if (tok_r && space_c) begin
                pend_nxt = has_r;
              end else if (pend_r) begin
                pend_nxt   = 1'b0;
                app_ch_nxt = CH_SPACE;
                again_nxt  = 1'b1;
                state_nxt  = S_WRD;
              end else begin
                app_ch_nxt = in_chan.symbol;
                again_nxt  = 1'b0;
                state_nxt  = S_WRD;
              end
            end
            OP_INS_END: begin
              res_lk_nxt   = 1'b0;
              ins_cur_nxt  = '0;
              pend_nxt     = 1'b0;
              has_nxt      = 1'b0;
              err_nxt      = 1'b0;
              err_code_nxt = ST_OK;
              state_nxt    = S_RESP;
              if (failed_r) begin
                res_st_nxt = ST_INVALID;
              end else if (in_chan.route_mode > MODE_BOTH ||
                           32'(in_chan.route_number) >= 32'(ROUTES)) begin
                res_st_nxt = ST_INVALID;
                failed_nxt = 1'b1;
              end else if (err_r) begin
                res_st_nxt = err_code_r;
                failed_nxt = 1'b1;
              end else if (!has_r) begin
                res_st_nxt = ST_INVALID;
                failed_nxt = 1'b1;
              end else begin
                ram_raddr = ins_cur_r;
                idx_nxt   = ins_cur_r;
                state_nxt = S_EI_CHK;
              end
            end
            OP_LKP_CHR: begin
              walk_lk_nxt = 1'b1;
              if (failed_r || ovf_r) begin
                state_nxt = S_IDLE;
              end else if (32'(len_r) >= 32'(MAX_PATH - 1)) begin
                ovf_nxt = 1'b1;
              end else if (!broken_r) begin
                app_ch_nxt = in_chan.symbol;
                state_nxt  = S_WRD;
              end else begin
                len_nxt = len_r + LW'(1);
              end
            end
            OP_LKP_END: begin
              res_lk_nxt = 1'b1;
              if (failed_r || ovf_r || len_r == '0) begin
                res_st_nxt = ST_INVALID;
                state_nxt  = S_RESP;
              end else if (!broken_r) begin
                ram_raddr = lk_cur_r;
                state_nxt = S_EL_CHK;
              end else begin
                state_nxt = S_RESP;
                if (best_v_r) begin
                  res_st_nxt   = ST_OK;
                  res_rt_nxt   = best_r;
                  res_kind_nxt = KIND_PREFIX;
                  res_off_nxt  = 8'(best_off_r);
                end else begin
                  res_st_nxt = ST_NOT_FOUND;
                end
              end
              if (state_nxt == S_RESP) begin
                lk_cur_nxt   = '0;
                broken_nxt   = 1'b0;
                ovf_nxt      = 1'b0;
                len_nxt      = '0;
                best_v_nxt   = 1'b0;
                best_off_nxt = '0;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        wnode     = '0;
        state_nxt = S_IDLE;
      end

      S_WRD: begin
        ram_raddr = walk_lk_r ? lk_cur_r : ins_cur_r;
        state_nxt = S_PAR;
      end

      S_PAR: begin
        par_nxt = rnode;
        if (walk_lk_r && rnode.pf_v) begin
          best_v_nxt   = 1'b1;
          best_nxt     = rnode.pf;
          best_off_nxt = len_r;
        end
        if (rnode.child_v) begin
          ram_raddr = rnode.child;
          idx_nxt   = rnode.child;
          state_nxt = S_SIB;
        end else begin
          miss_c = 1'b1;
        end
      end

      S_SIB: begin
        if (rnode.ch == app_ch_r) begin
          found_c = 1'b1;
        end else if (rnode.sib_v) begin
          ram_raddr = rnode.sib;
          idx_nxt   = rnode.sib;
        end else begin
          miss_c = 1'b1;
        end
      end

      S_ALLOC: begin
        if (32'(used_r) >= 32'(NODES)) begin
          err_nxt      = 1'b1;
          err_code_nxt = ST_FULL;
          state_nxt    = S_IDLE;
        end else begin
          wnode         = '0;
          wnode.ch      = app_ch_r;
          wnode.sib_v   = par_r.child_v;
          wnode.sib     = par_r.child;
          ram_we        = 1'b1;
          ram_waddr     = used_r[NW-1:0];
          idx_nxt       = used_r[NW-1:0];
          used_nxt      = used_r + CW'(1);
          state_nxt     = S_LINK;
        end
      end

      S_LINK: begin
        wnode         = par_r;
        wnode.child_v = 1'b1;
        wnode.child   = idx_r;
        ram_we        = 1'b1;
        ram_waddr     = ins_cur_r;
        ins_cur_nxt   = idx_r;
        done_app_c    = 1'b1;
      end

      S_EI_CHK: begin
        wnode      = rnode;
        res_st_nxt = ST_OK;
        case (mode_r)
          MODE_EXACT: begin
            if (rnode.ex_v) begin
              res_st_nxt = ST_DUPLICATE;
            end else begin
              wnode.ex_v = 1'b1;
              wnode.ex   = route_r;
              ram_we     = 1'b1;
            end
          end
          MODE_PREFIX: begin
            if (rnode.pf_v) begin
              res_st_nxt = ST_DUPLICATE;
            end else begin
              wnode.pf_v = 1'b1;
              wnode.pf   = route_r;
              ram_we     = 1'b1;
            end
          end
          default: begin
            // Both kinds: a duplicate on either side leaves the node untouched.
            if (rnode.ex_v || rnode.pf_v) begin
              res_st_nxt = ST_DUPLICATE;
            end else begin
              wnode.ex_v = 1'b1;
              wnode.ex   = route_r;
              wnode.pf_v = 1'b1;
              wnode.pf   = route_r;
              ram_we     = 1'b1;
            end
          end
        endcase
        ram_waddr = idx_r;
        if (res_st_nxt != ST_OK) begin
          failed_nxt = 1'b1;
        end
        state_nxt = S_RESP;
      end

      S_EL_CHK: begin
        if (rnode.ex_v) begin
          res_st_nxt   = ST_OK;
          res_rt_nxt   = rnode.ex;
          res_kind_nxt = KIND_EXACT;
          res_off_nxt  = 8'(len_r);
        end else if (best_v_r) begin
          res_st_nxt   = ST_OK;
          res_rt_nxt   = best_r;
          res_kind_nxt = KIND_PREFIX;
          res_off_nxt  = 8'(best_off_r);
        end else begin
          res_st_nxt = ST_NOT_FOUND;
        end
        lk_cur_nxt   = '0;
        broken_nxt   = 1'b0;
        ovf_nxt      = 1'b0;
        len_nxt      = '0;
        best_v_nxt   = 1'b0;
        best_off_nxt = '0;
        state_nxt    = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (found_c) begin
      if (walk_lk_r) begin
        lk_cur_nxt = idx_r;
        len_nxt    = len_r + LW'(1);
        state_nxt  = S_IDLE;
      end else begin
        ins_cur_nxt = idx_r;
        done_app_c  = 1'b1;
      end
    end
    if (miss_c) begin
      if (walk_lk_r) begin
        broken_nxt = 1'b1;
        len_nxt    = len_r + LW'(1);
        state_nxt  = S_IDLE;
      end else begin
        state_nxt = S_ALLOC;
      end
    end
    // An append is done: after a pending space the character itself follows, else the item ends.
    if (done_app_c) begin
      if (again_r) begin
        again_nxt  = 1'b0;
        app_ch_nxt = sym_r;
        state_nxt  = S_WRD;
      end else begin
        has_nxt   = 1'b1;
        state_nxt = S_IDLE;
      end
    end

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      tok_r       <= 1'b0;
      used_r      <= CW'(1);
      failed_r    <= 1'b0;
      ins_cur_r   <= '0;
      pend_r      <= 1'b0;
      has_r       <= 1'b0;
      err_r       <= 1'b0;
      err_code_r  <= ST_OK;
      lk_cur_r    <= '0;
      broken_r    <= 1'b0;
      ovf_r       <= 1'b0;
      len_r       <= '0;
      best_v_r    <= 1'b0;
      best_off_r  <= '0;
      again_r     <= 1'b0;
      walk_lk_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        tok_r <= cfg_wdata;
      end
      used_r      <= used_nxt;
      failed_r    <= failed_nxt;
      ins_cur_r   <= ins_cur_nxt;
      pend_r      <= pend_nxt;
      has_r       <= has_nxt;
      err_r       <= err_nxt;
      err_code_r  <= err_code_nxt;
      lk_cur_r    <= lk_cur_nxt;
      broken_r    <= broken_nxt;
      ovf_r       <= ovf_nxt;
      len_r       <= len_nxt;
      best_v_r    <= best_v_nxt;
      best_off_r  <= best_off_nxt;
      again_r     <= again_nxt;
      walk_lk_r   <= walk_lk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    sym_r      <= sym_nxt;
    route_r    <= route_nxt;
    mode_r     <= mode_nxt;
    app_ch_r   <= app_ch_nxt;
    idx_r      <= idx_nxt;
    par_r      <= par_nxt;
    res_st_r   <= res_st_nxt;
    res_lk_r   <= res_lk_nxt;
    res_kind_r <= res_kind_nxt;
    res_rt_r   <= res_rt_nxt;
    res_off_r  <= res_off_nxt;
    if (load_out) begin
      out_st_r   <= res_st_r;
      out_lk_r   <= res_lk_r;
      out_kind_r <= res_kind_r;
      out_rt_r   <= res_rt_r;
      out_off_r  <= res_off_r;
    end
  end

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != '0) && (32'(used_r) <= 32'(NODES)))
    else $error("node count out of range");

  a_write_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (32'(ram_waddr) < 32'(used_r)) || (state_r == S_ALLOC))
    else $error("node write beyond allocated nodes");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && !res_lk_r && res_st_r != ST_OK) |-> failed_r)
    else $error("failed end insert did not mark the table failed");

  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && (state_r == S_IDLE))
    else $error("result not presented after load");
`endif

endmodule
